// ===== sv/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants for the pair-keyed count-min sketch
// Hash constants, per-row seed function and the item token that moves
// along the row cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam int          MIX_SHIFT = 33;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Width of the clamped size values
  localparam int SIZE_W = 5;

  typedef logic signed [47:0] count_t;

  // Item token handed from cell to cell
  typedef struct packed {
    logic               op;
    logic [63:0]        base;
    logic signed [31:0] weight;
    count_t             est;
  } token_t;

  // Murmur finalizer, used only on constants at elaboration
  function automatic logic [63:0] fin64_const(input logic [63:0] x);
    logic [63:0] v;
    v = x;
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_C1;
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_C2;
    v = v ^ (v >> MIX_SHIFT);
    return v;
  endfunction

  // Hardwired seed of a row
  function automatic logic [63:0] row_seed(input int row);
    logic [63:0] g;
    g = GOLDEN * 64'(row + 1);
    return fin64_const(g);
  endfunction

endpackage

`default_nettype wire

// ===== sv/cms_ram.sv =====
// ----------------------------------------------------------------------------
// cms_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/cms_mul64.sv =====
// ----------------------------------------------------------------------------
// cms_mul64: low 64 bits of a 64x64 product
// One 32x32 multiplier used over three partial products in turn; done and
// the product are registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_mul64 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [1:0]  step;
  logic        run;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  // operand select per step: lo*lo, lo*hi, hi*lo
  always_comb begin
    case (step)
      2'd1:    begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
      2'd2:    begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
      default: begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= 2'd0;
      end else if (run) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // product register and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    prod <= 64'(op_a) * 64'(op_b);
    if (run) begin
      case (step)
        2'd1:    p <= prod;
        2'd2:    p <= p + {prod[31:0], 32'd0};
        2'd3:    p <= p + {prod[31:0], 32'd0};
        default: p <= p;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/cms_fin64.sv =====
// ----------------------------------------------------------------------------
// cms_fin64: 64-bit murmur finalizer
// Two sequential constant multiplies on the shared partial-product unit;
// done and the result are registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_fin64 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] v,
  output logic             done,
  output logic [63:0]      h
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_M1   = 2'd1;
  localparam logic [1:0] ST_M2   = 2'd2;

  logic [1:0]  state;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_p;
  logic [63:0] mixed;

  assign mixed = mul_p ^ (mul_p >> cms_pkg::MIX_SHIFT);

  always_comb begin
    mul_start = start || (state == ST_M1 && mul_done);
    if (state == ST_M1) begin
      mul_a = mixed;
      mul_b = cms_pkg::MIX_C2;
    end else begin
      mul_a = v ^ (v >> cms_pkg::MIX_SHIFT);
      mul_b = cms_pkg::MIX_C1;
    end
  end

  cms_mul64 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: if (start) state <= ST_M1;
        ST_M1:   if (mul_done) state <= ST_M2;
        ST_M2: begin
          if (mul_done) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_M2 && mul_done) begin
      h <= mixed;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cms_cell.sv =====
// ----------------------------------------------------------------------------
// cms_cell: one hash row of the sketch
// Hashes the folded key with the row seed, reads its counter bank, writes it
// back on updates, folds it into the running minimum and hands the item on.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_cell #(
  parameter int ROW              = 0,
  parameter int MAX_COLUMNS_LOG2 = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire cms_pkg::token_t               in_tok,
  input  wire logic [cms_pkg::SIZE_W-1:0]    clog_eff,
  input  wire logic                          clr_we,
  input  wire logic [MAX_COLUMNS_LOG2-1:0]   clr_addr,
  output logic                               out_valid,
  output cms_pkg::token_t                    out_tok
);

  localparam logic [63:0] SEED = cms_pkg::row_seed(ROW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  logic [1:0]                  state;
  cms_pkg::token_t             tok;
  logic [MAX_COLUMNS_LOG2-1:0] col;
  logic [MAX_COLUMNS_LOG2-1:0] col_mask;
  logic                        fin_done;
  logic [63:0]                 fin_h;
  logic [47:0]                 rdata;
  cms_pkg::count_t             cur;
  logic signed [48:0]          sum49;
  cms_pkg::count_t             sat;
  cms_pkg::count_t             val;
  cms_pkg::count_t             est_next;
  logic                        wb_we;
  logic                        ram_we;
  logic [MAX_COLUMNS_LOG2-1:0] ram_waddr;
  logic [47:0]                 ram_wdata;

  // column mask from the clamped column count
  always_comb begin
    for (int i = 0; i < MAX_COLUMNS_LOG2; i++) begin
      col_mask[i] = (cms_pkg::SIZE_W'(i) < clog_eff);
    end
  end

  cms_fin64 u_fin (
    .clk   (clk),
    .rst   (rst),
    .start (in_valid),
    .v     (in_tok.base ^ SEED),
    .done  (fin_done),
    .h     (fin_h)
  );

  // saturating counter update and running minimum
  always_comb begin
    cur   = cms_pkg::count_t'(rdata);
    sum49 = {cur[47], cur} + 49'(tok.weight);
    if (sum49[48] != sum49[47]) begin
      sat = sum49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sat = sum49[47:0];
    end
    val = (tok.op == cms_pkg::OP_UPDATE) ? sat : cur;
    if (ROW == 0 || val < tok.est) begin
      est_next = val;
    end else begin
      est_next = tok.est;
    end
  end

  assign wb_we     = (state == ST_WB) && (tok.op == cms_pkg::OP_UPDATE);
  assign ram_we    = clr_we || wb_we;
  assign ram_waddr = clr_we ? clr_addr : col;
  assign ram_wdata = clr_we ? 48'd0 : val;

  cms_ram #(
    .WIDTH (48),
    .DEPTH (1 << MAX_COLUMNS_LOG2)
  ) u_bank (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col),
    .rdata (rdata)
  );

  // row sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid) state <= ST_HASH;
        ST_HASH: if (fin_done) state <= ST_RD;
        ST_RD:   state <= ST_WB;
        ST_WB: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      tok <= in_tok;
    end
    if (state == ST_HASH && fin_done) begin
      col <= fin_h[MAX_COLUMNS_LOG2-1:0] & col_mask;
    end
    if (state == ST_WB) begin
      out_tok.op     <= tok.op;
      out_tok.base   <= tok.base;
      out_tok.weight <= tok.weight;
      out_tok.est    <= est_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/count_min_sketch_pair_keys.sv =====
// ----------------------------------------------------------------------------
// count_min_sketch_pair_keys: count-min sketch keyed by a key pair
// Top level: command port, key folding front end, row cell chain, totals.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with operation, source_key, target_key and weight while busy
//   is low; the item is taken at that edge. An update adds weight to one
//   counter per active row; a query leaves the state untouched.
//   Each item gives one result: done is high for one cycle with estimate,
//   records_count and total_weight. The receiver cannot stall; the result
//   registers hold until the next item finishes.
//   Sequence: folding the key pair takes two finalizer passes and one
//   multiply, then each active row cell hashes, reads and, on an update,
//   writes its counter bank, the rows one after another. One item is in
//   flight at a time: busy stays high from the accepted item until done.
//   After reset a clearing pass zeroes every column of the counter banks,
//   one column of all rows per cycle, with busy high. Registers are to be
//   written over the APB-style port only while idle; the block itself
//   does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module count_min_sketch_pair_keys #(
  parameter int MAX_COLUMNS_LOG2 = 10,
  parameter int MAX_ROWS         = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation,
  input  wire logic [63:0]        source_key,
  input  wire logic [63:0]        target_key,
  input  wire logic signed [31:0] weight,
  output logic                    done,
  output logic signed [47:0]      estimate,
  output logic [31:0]             records_count,
  output logic signed [63:0]      total_weight,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int SW = cms_pkg::SIZE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_FS   = 3'd2;
  localparam logic [2:0] ST_FT   = 3'd3;
  localparam logic [2:0] ST_MG   = 3'd4;
  localparam logic [2:0] ST_RUN  = 3'd5;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  logic [2:0]                  state;
  logic [3:0]                  columns_log2;
  logic [3:0]                  rows_in_use;
  logic [SW-1:0]               clog_eff;
  logic [SW-1:0]               rows_eff;
  logic [MAX_COLUMNS_LOG2-1:0] clr_addr;
  logic                        clr_we;
  logic                        accept;

  logic               op_q;
  logic [63:0]        target_q;
  logic signed [31:0] weight_q;
  logic [63:0]        fs_q;

  logic        fin_start;
  logic [63:0] fin_v;
  logic        fin_done;
  logic [63:0] fin_h;
  logic        mul_done;
  logic [63:0] mul_p;

  logic            front_valid;
  cms_pkg::token_t front_tok;

  logic            cell_in_valid [MAX_ROWS];
  cms_pkg::token_t cell_in_tok   [MAX_ROWS];
  logic            cell_valid    [MAX_ROWS];
  cms_pkg::token_t cell_tok      [MAX_ROWS];
  logic            cell_last     [MAX_ROWS];
  logic [MAX_ROWS-1:0] fin_vec;
  logic            fin_any;
  cms_pkg::count_t fin_est;

  logic signed [64:0] sum65;
  logic signed [63:0] sum_next;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign clr_we = (state == ST_CLR);
  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_log2 <= 4'd10;
      rows_in_use  <= 4'd4;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_COLUMNS: columns_log2 <= pwdata[3:0];
        REG_ROWS:    rows_in_use  <= pwdata[3:0];
        default:     ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_ROWS) ? {28'd0, rows_in_use} : {28'd0, columns_log2};

  // clamp sizes into their legal range
  always_comb begin
    if (columns_log2 == 4'd0) begin
      clog_eff = SW'(1);
    end else if (SW'(columns_log2) > SW'(MAX_COLUMNS_LOG2)) begin
      clog_eff = SW'(MAX_COLUMNS_LOG2);
    end else begin
      clog_eff = SW'(columns_log2);
    end
    if (rows_in_use == 4'd0) begin
      rows_eff = SW'(1);
    end else if (SW'(rows_in_use) > SW'(MAX_ROWS)) begin
      rows_eff = SW'(MAX_ROWS);
    end else begin
      rows_eff = SW'(rows_in_use);
    end
  end

  // key folding: M(source) ^ (M(target) * G)
  assign fin_start = accept || (state == ST_FS && fin_done);
  assign fin_v     = (state == ST_FS) ? target_q : source_key;

  cms_fin64 u_fin (
    .clk   (clk),
    .rst   (rst),
    .start (fin_start),
    .v     (fin_v),
    .done  (fin_done),
    .h     (fin_h)
  );

  cms_mul64 u_gold (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_FT && fin_done),
    .a     (fin_h),
    .b     (cms_pkg::GOLDEN),
    .done  (mul_done),
    .p     (mul_p)
  );

  // row cell chain
  genvar gi;
  generate
    for (gi = 0; gi < MAX_ROWS; gi++) begin : g_row
      if (gi == 0) begin : g_head
        assign cell_in_valid[gi] = front_valid;
        assign cell_in_tok[gi]   = front_tok;
      end else begin : g_link
        assign cell_in_valid[gi] = cell_valid[gi-1] && !cell_last[gi-1];
        assign cell_in_tok[gi]   = cell_tok[gi-1];
      end
      assign cell_last[gi] = (rows_eff == SW'(gi + 1));
      assign fin_vec[gi]   = cell_valid[gi] && cell_last[gi];

      cms_cell #(
        .ROW              (gi),
        .MAX_COLUMNS_LOG2 (MAX_COLUMNS_LOG2)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (cell_in_valid[gi]),
        .in_tok    (cell_in_tok[gi]),
        .clog_eff  (clog_eff),
        .clr_we    (clr_we),
        .clr_addr  (clr_addr),
        .out_valid (cell_valid[gi]),
        .out_tok   (cell_tok[gi])
      );
    end
  endgenerate

  // pick the result from the last active row
  always_comb begin
    fin_any = 1'b0;
    fin_est = '0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      if (fin_vec[i]) begin
        fin_any = 1'b1;
        fin_est = cell_tok[i].est;
      end
    end
  end

  // saturating running total
  always_comb begin
    sum65 = {total_weight[63], total_weight} + 65'(weight_q);
    if (sum65[64] != sum65[63]) begin
      sum_next = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_next = sum65[63:0];
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_addr      <= '0;
      front_valid   <= 1'b0;
      done          <= 1'b0;
      records_count <= 32'd0;
      total_weight  <= 64'sd0;
    end else begin
      front_valid <= 1'b0;
      done        <= 1'b0;
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) state <= ST_IDLE;
        end
        ST_IDLE: if (accept) state <= ST_FS;
        ST_FS:   if (fin_done) state <= ST_FT;
        ST_FT:   if (fin_done) state <= ST_MG;
        ST_MG: begin
          if (mul_done) begin
            front_valid <= 1'b1;
            state       <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (fin_any) begin
            done  <= 1'b1;
            state <= ST_IDLE;
            if (op_q == cms_pkg::OP_UPDATE) begin
              if (records_count != 32'hFFFF_FFFF) records_count <= records_count + 32'd1;
              total_weight <= sum_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= operation;
      target_q <= target_key;
      weight_q <= weight;
    end
    if (state == ST_FS && fin_done) begin
      fs_q <= fin_h;
    end
    if (state == ST_MG && mul_done) begin
      front_tok.op     <= op_q;
      front_tok.base   <= fs_q ^ mul_p;
      front_tok.weight <= weight_q;
      front_tok.est    <= '0;
    end
    if (state == ST_RUN && fin_any) begin
      estimate <= fin_est;
    end
  end

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted item did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_one_final: assert property (@(posedge clk) disable iff (rst)
    $onehot0(fin_vec)) else $error("more than one row cell finished an item");

  a_final_in_run: assert property (@(posedge clk) disable iff (rst)
    fin_any |-> (state == ST_RUN)) else $error("row result outside run state");

endmodule

`default_nettype wire
